// File: rtl/three_channel_reload_down_timer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the reload down-timer bank
// Clocked implication checks that vanish from synthesis builds.
// ---------------------------------------------------------------------------
`ifndef THREE_CHANNEL_RELOAD_DOWN_TIMER_TOP_MACROS_SVH
`define THREE_CHANNEL_RELOAD_DOWN_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCRDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer bank check failed");
// next-cycle implication
`define TCRDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer bank check failed");
`else
`define TCRDT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TCRDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/tcrdt_pkg.sv
// ---------------------------------------------------------------------------
// Reload down-timer bank package
// Transaction types, operation codes, register offsets and bit positions.
// ---------------------------------------------------------------------------
package tcrdt_pkg;

    // default sizing
    localparam int DEF_CHANNELS    = 3;
    localparam int DEF_COUNT_WIDTH = 32;

    // operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register map
    localparam logic [5:0] OFF_TOCR    = 6'h00;
    localparam logic [5:0] OFF_TSTR    = 6'h04;
    localparam int         OFF_CH_BASE = 8;
    localparam int         CH_STRIDE   = 12;
    localparam int         REL_TCOR    = 0;
    localparam int         REL_TCNT    = 4;
    localparam int         REL_TCR     = 8;

    // control word bits
    localparam int MODE_W        = 3;
    localparam int ENABLE_BIT    = 5;
    localparam int UNDERFLOW_BIT = 8;
    localparam int CLEAR_BIT     = 9;
    localparam int CTRL_W        = 16;
    localparam int TOCR_W        = 8;

    localparam logic [MODE_W-1:0] MODE_MAX = 3'd4;

    // divider
    localparam int              PRESCALE_W  = 12;
    localparam int              SHIFT_W     = 4;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic [1:0]        operation;
        logic [5:0]        reg_offset;
        logic [DATA_W-1:0] write_value;
    } tcrdt_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic              read_ok;
        logic              irq_channel0;
        logic              irq_channel1;
        logic              irq_channel2;
    } tcrdt_rsp_t;

endpackage

// File: rtl/three_channel_reload_down_timer_top.sv
// ---------------------------------------------------------------------------
// Three-channel reload down-timer bank
// Register bank of down-counters sharing a prescaler, one transaction per cycle unless the result is stalled.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one transaction: a clock
//   tick, a register write or a register read. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one result per request: read data, the
//   read status and the three interrupt request levels after the transaction.
//   A request accepted into the input register is executed as it leaves
//   that register, when its result is loaded into the result register.
//   One transaction per cycle while no result is stalled, with a single pass
//   of tick, write and read logic between input and result register.
//   A stalled result holds the result register; the input register keeps
//   its transaction and req_stall rises only while both registers are full,
//   so the bank never executes a transaction whose result cannot be held.
//   Reset (rst_n low, asynchronous) empties both registers and loads counts
//   and reloads with all ones, control words and start bits with zero, the
//   dividers with sixteen ticks and the prescaler with zero.
// ---------------------------------------------------------------------------
`include "three_channel_reload_down_timer_top_macros.svh"

module three_channel_reload_down_timer_top
    import tcrdt_pkg::*;
#(
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  tcrdt_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output tcrdt_rsp_t rsp
);

    localparam int IRQ_OUT = 3;

    // pipeline registers
    logic       s1_valid_reg;
    logic       s1_valid_next;
    tcrdt_req_t s1_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    tcrdt_rsp_t rsp_reg;
    tcrdt_rsp_t rsp_next;

    // bank state
    logic [COUNT_WIDTH-1:0] count_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] count_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] reload_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] reload_next[CHANNELS];
    logic [CTRL_W-1:0]      ctrl_reg   [CHANNELS];
    logic [CTRL_W-1:0]      ctrl_next  [CHANNELS];
    logic [SHIFT_W-1:0]     div_reg    [CHANNELS];
    logic [SHIFT_W-1:0]     div_next   [CHANNELS];
    logic [CHANNELS-1:0]    start_reg;
    logic [CHANNELS-1:0]    start_next;
    logic [TOCR_W-1:0]      tocr_reg;
    logic [TOCR_W-1:0]      tocr_next;
    logic [PRESCALE_W-1:0]  prescale_reg;
    logic [PRESCALE_W-1:0]  prescale_next;

    logic                   advance;
    logic                   accept;
    logic                   fire;
    logic [CHANNELS-1:0]    irq_cur;
    logic [CHANNELS-1:0]    irq_new;
    logic [CHANNELS+IRQ_OUT-1:0] irq_cur_pad;
    logic [CHANNELS+IRQ_OUT-1:0] irq_new_pad;

    // handshake
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign fire      = s1_valid_reg && advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign s1_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = fire ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    // execute one transaction against the bank
    always_comb
    begin
        logic [PRESCALE_W-1:0]  span;
        logic [COUNT_WIDTH-1:0] dec;
        logic [CTRL_W-1:0]      tcr;
        logic [7:0]             off;

        span = '0;
        dec  = '0;
        tcr  = '0;
        off  = {2'b00, s1_reg.reg_offset};

        count_next    = count_reg;
        reload_next   = reload_reg;
        ctrl_next     = ctrl_reg;
        div_next      = div_reg;
        start_next    = start_reg;
        tocr_next     = tocr_reg;
        prescale_next = prescale_reg;

        rsp_next            = '0;
        rsp_next.read_ok    = 1'b1;

        case (s1_reg.operation)
            OP_TICK:
            begin
                prescale_next = prescale_reg + 1'b1;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    span = PRESCALE_W'((16'd1 << div_reg[c]) - 16'd1);
                    dec  = count_reg[c] - 1'b1;
                    if (start_reg[c])
                    begin
                        if (count_reg[c] == '0)
                        begin
                            count_next[c]                = reload_reg[c];
                            ctrl_next[c][UNDERFLOW_BIT]  = 1'b1;
                        end
                        else if ((prescale_next & span) == '0)
                        begin
                            if (dec == '0)
                            begin
                                count_next[c]               = reload_reg[c];
                                ctrl_next[c][UNDERFLOW_BIT] = 1'b1;
                            end
                            else
                            begin
                                count_next[c] = dec;
                            end
                        end
                    end
                end
            end
            OP_WRITE:
            begin
                if (s1_reg.reg_offset == OFF_TOCR)
                begin
                    tocr_next = s1_reg.write_value[TOCR_W-1:0];
                end
                else if (s1_reg.reg_offset == OFF_TSTR)
                begin
                    start_next = s1_reg.write_value[CHANNELS-1:0];
                end
                else
                begin
                    tcr = s1_reg.write_value[CTRL_W-1:0];
                    // flag and clear bit together drop the upper byte
                    if (tcr[UNDERFLOW_BIT] && tcr[CLEAR_BIT])
                    begin
                        tcr = {8'h00, tcr[7:0]};
                    end
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (off == 8'(OFF_CH_BASE + CH_STRIDE * c + REL_TCOR))
                        begin
                            reload_next[c] = s1_reg.write_value[COUNT_WIDTH-1:0];
                        end
                        else if (off == 8'(OFF_CH_BASE + CH_STRIDE * c + REL_TCNT))
                        begin
                            count_next[c] = s1_reg.write_value[COUNT_WIDTH-1:0];
                        end
                        else if (off == 8'(OFF_CH_BASE + CH_STRIDE * c + REL_TCR))
                        begin
                            ctrl_next[c] = tcr;
                            // reserved modes keep the old divider
                            if (tcr[MODE_W-1:0] <= MODE_MAX)
                            begin
                                div_next[c] = {tcr[MODE_W-1:0], 1'b0} + SHIFT_RESET;
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                rsp_next.read_ok = 1'b0;
                if (s1_reg.reg_offset == OFF_TSTR)
                begin
                    rsp_next.read_value = DATA_W'(start_reg);
                    rsp_next.read_ok    = 1'b1;
                end
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (off == 8'(OFF_CH_BASE + CH_STRIDE * c + REL_TCNT))
                    begin
                        rsp_next.read_value = DATA_W'(count_reg[c]);
                        rsp_next.read_ok    = 1'b1;
                    end
                end
            end
            default:
            begin
                rsp_next.read_ok = 1'b1;
            end
        endcase

        // interrupt levels after the transaction
        for (int c = 0; c < CHANNELS; c++)
        begin
            irq_new[c] = ctrl_next[c][UNDERFLOW_BIT] && ctrl_next[c][ENABLE_BIT];
            irq_cur[c] = ctrl_reg[c][UNDERFLOW_BIT] && ctrl_reg[c][ENABLE_BIT];
        end
        irq_new_pad = {{IRQ_OUT{1'b0}}, irq_new};
        irq_cur_pad = {{IRQ_OUT{1'b0}}, irq_cur};
        rsp_next.irq_channel0 = irq_new_pad[0];
        rsp_next.irq_channel1 = irq_new_pad[1];
        rsp_next.irq_channel2 = irq_new_pad[2];
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // bank state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c]  <= '1;
                reload_reg[c] <= '1;
                ctrl_reg[c]   <= '0;
                div_reg[c]    <= SHIFT_RESET;
            end
            start_reg    <= '0;
            tocr_reg     <= '0;
            prescale_reg <= '0;
        end
        else if (fire)
        begin
            count_reg    <= count_next;
            reload_reg   <= reload_next;
            ctrl_reg     <= ctrl_next;
            div_reg      <= div_next;
            start_reg    <= start_next;
            tocr_reg     <= tocr_next;
            prescale_reg <= prescale_next;
        end
    end

    // checks
    `TCRDT_ASSERT_IMP(a_stall_when_full, clk, rst_n, s1_valid_reg && rsp_valid_reg && rsp_stall, req_stall)
    `TCRDT_ASSERT_NEXT(a_prescale_tick_only, clk, rst_n, !(fire && s1_reg.operation == OP_TICK), $stable(prescale_reg))
    `TCRDT_ASSERT_IMP(a_irq0_tracks, clk, rst_n, rsp_valid_reg, rsp_reg.irq_channel0 == irq_cur_pad[0])
    `TCRDT_ASSERT_IMP(a_irq1_tracks, clk, rst_n, rsp_valid_reg, rsp_reg.irq_channel1 == irq_cur_pad[1])

endmodule
